@@ src/jivl_pkg.sv @@
// Package for the inverse-Jacobian velocity law pipeline.
// Holds widths and the stage payload types shared by all modules; no dependencies.
`default_nettype none
package jivl_pkg;
    localparam int AXES = 3;
    localparam int PW16 = 16;           // pixel and register width
    localparam int JW   = 24;           // Jacobian element, Q8.16
    localparam int EW   = 17;           // pixel error
    localparam int CW   = 49;           // cofactor, Q17.32
    localparam int CLW  = 24;           // low split of a cofactor
    localparam int DW   = 75;           // determinant
    localparam int NW   = 67;           // adjugate times error
    localparam int KW   = 20;           // gain times 16
    localparam int PW   = 88;           // scaled numerator and divider words
    localparam int SPW  = 8;            // speed byte
    localparam int QSTEPS = 8;          // quotient bits
    localparam int IN_W  = 248;
    localparam int OUT_W = 32;

    localparam logic [1:0] REG_GOAL_X = 2'd0;
    localparam logic [1:0] REG_GOAL_Y = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    // cofactor rows: 0 feeds the determinant, 1 and 2 the adjugate columns
    typedef struct packed {
        logic [AXES-1:0][JW-1:0]            j0;
        logic [2:0][AXES-1:0][CW-1:0]       cf;
        logic signed [EW-1:0]               e1;
        logic signed [EW-1:0]               e2;
    } cof_t;

    typedef struct packed {
        logic [PW-1:0]  num;
        logic [PW-1:0]  den7;
        logic [SPW-1:0] q;
        logic           sat;
        logic           kill;
        logic           dir;
    } ax_t;

    typedef struct packed {
        ax_t [AXES-1:0] ax;
        logic           sing;
    } dv_t;
endpackage
`default_nettype wire

@@ src/jacobian_inverse_velocity_law.sv @@
// Top level: inverse-Jacobian velocity law, stream in and out.
// Depends on jivl_pkg, jivl_cofactor, jivl_combine, jivl_div_step.
//
//  channel  ports        payload, lowest bit first
//  input    s_t*         marker_x, marker_y, jac_00..jac_22 (248 bits)
//  result   m_t*         dir_a, speed_a, dir_b, speed_b, dir_c, speed_c, singular
//  config   cfg_*        0 goal_x, 1 goal_y, 2 gain
//
// One transfer per cycle in steady state while the output is not stalled;
// the pipeline holds 2 cofactor, 7 combine and 8 divider stages and the output register.
// The whole pipeline advances together when the output register is empty
// or being taken; a stall freezes every stage. Reset clears valid bits and
// the configuration registers.
`default_nettype none
module jacobian_inverse_velocity_law import jivl_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // marker_x, marker_y, jac_00, jac_01, jac_02, jac_10, jac_11, jac_12,
    // jac_20, jac_21, jac_22
    input  wire logic [IN_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // dir_a, speed_a, dir_b, speed_b, dir_c, speed_c, singular, zero pad
    output logic [OUT_W-1:0]        m_tdata,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [PW16-1:0]    cfg_wdata
);
    logic [PW16-1:0] goal_x_reg, goal_y_reg, gain_reg;
    logic            en;
    logic            v_cof, v_cmb;
    cof_t            cof;
    dv_t             dv [QSTEPS+1];
    logic            vd [QSTEPS+1];
    logic [8:0][JW-1:0] jac;
    logic            m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic [SPW-1:0]  spd [AXES];
    logic [AXES-1:0] dirv;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            jac[i] = s_tdata[2*PW16 + JW*i +: JW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            gain_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GOAL_X: goal_x_reg <= cfg_wdata;
                REG_GOAL_Y: goal_y_reg <= cfg_wdata;
                REG_GAIN:   gain_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    jivl_cofactor u_cof (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vin(s_tvalid && s_tready),
        .jac(jac), .mx(s_tdata[PW16-1:0]), .my(s_tdata[2*PW16-1:PW16]),
        .gx(goal_x_reg), .gy(goal_y_reg), .vout(v_cof), .cof(cof)
    );

    jivl_combine u_cmb (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vin(v_cof), .cof(cof),
        .gain(gain_reg), .vout(v_cmb), .dv(dv[0])
    );
    assign vd[0] = v_cmb;

    for (genvar g = 0; g < QSTEPS; g++) begin : g_div
        jivl_div_step u_step (
            .aclk(aclk), .aresetn(aresetn), .en(en), .vin(vd[g]),
            .din(dv[g]), .vout(vd[g+1]), .dout(dv[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            if (dv[QSTEPS].ax[i].kill) begin
                spd[i]  = '0;
                dirv[i] = 1'b1;
            end else begin
                spd[i]  = dv[QSTEPS].ax[i].sat ? {SPW{1'b1}} : dv[QSTEPS].ax[i].q;
                dirv[i] = dv[QSTEPS].ax[i].dir;
            end
        end
        // actuators A, B, C take axes 2, 0, 1
        m_tdata_next = {4'b0000, dv[QSTEPS].sing, spd[1], dirv[1],
                        spd[0], dirv[0], spd[2], dirv[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vd[QSTEPS];
        end
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule
`default_nettype wire

@@ src/jivl_cofactor.sv @@
// Two stages: 24x24 products and pixel error, then cofactor differences.
// Depends on jivl_pkg.
`default_nettype none
module jivl_cofactor import jivl_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   vin,
    input  wire logic [8:0][JW-1:0]     jac,
    input  wire logic [PW16-1:0]        mx,
    input  wire logic [PW16-1:0]        my,
    input  wire logic [PW16-1:0]        gx,
    input  wire logic [PW16-1:0]        gy,
    output logic                        vout,
    output cof_t                        cof
);
    logic signed [2*JW-1:0] pa_reg [9];
    logic signed [2*JW-1:0] pb_reg [9];
    logic signed [2*JW-1:0] pa_next [9];
    logic signed [2*JW-1:0] pb_next [9];
    logic [AXES-1:0][JW-1:0] j0_reg;
    logic signed [EW-1:0]    e1_reg, e2_reg;
    logic                    v1_reg, v2_reg;
    cof_t                    cof_reg, cof_next;

    function automatic logic signed [2*JW-1:0] mj(input logic [JW-1:0] a,
                                                  input logic [JW-1:0] b);
        mj = $signed(a) * $signed(b);
    endfunction

    // element r,c sits at jac[3r+c]; cofactor = pa - pb
    always_comb begin
        pa_next[0] = mj(jac[4], jac[8]); pb_next[0] = mj(jac[5], jac[7]);
        pa_next[1] = mj(jac[5], jac[6]); pb_next[1] = mj(jac[3], jac[8]);
        pa_next[2] = mj(jac[3], jac[7]); pb_next[2] = mj(jac[4], jac[6]);
        pa_next[3] = mj(jac[2], jac[7]); pb_next[3] = mj(jac[1], jac[8]);
        pa_next[4] = mj(jac[0], jac[8]); pb_next[4] = mj(jac[2], jac[6]);
        pa_next[5] = mj(jac[1], jac[6]); pb_next[5] = mj(jac[0], jac[7]);
        pa_next[6] = mj(jac[1], jac[5]); pb_next[6] = mj(jac[2], jac[4]);
        pa_next[7] = mj(jac[2], jac[3]); pb_next[7] = mj(jac[0], jac[5]);
        pa_next[8] = mj(jac[0], jac[4]); pb_next[8] = mj(jac[1], jac[3]);
    end

    always_comb begin
        cof_next.j0 = j0_reg;
        cof_next.e1 = e1_reg;
        cof_next.e2 = e2_reg;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < AXES; c++) begin
                cof_next.cf[r][c] = CW'(pa_reg[3*r+c]) - CW'(pb_reg[3*r+c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= vin;
            v2_reg <= v1_reg;
        end
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                pa_reg[i] <= pa_next[i];
                pb_reg[i] <= pb_next[i];
            end
            j0_reg  <= {jac[2], jac[1], jac[0]};
            e1_reg  <= EW'($signed(mx)) - EW'($signed(gx));
            e2_reg  <= EW'($signed(my)) - EW'($signed(gy));
            cof_reg <= cof_next;
        end
    end

    assign vout = v2_reg;
    assign cof  = cof_reg;
endmodule
`default_nettype wire

@@ src/jivl_combine.sv @@
// Seven stages: determinant and adjugate-times-error from split products,
// magnitudes, gain scaling and the saturation test. Depends on jivl_pkg.
`default_nettype none
module jivl_combine import jivl_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           vin,
    input  wire cof_t           cof,
    input  wire logic [PW16-1:0] gain,
    output logic                vout,
    output dv_t                 dv
);
    localparam int HW  = CW - CLW;          // high split, signed
    localparam int PDW = JW + HW;           // det partial
    localparam int PNW = HW + EW;           // error partial
    localparam int SDW = PDW + 2;
    localparam int SNW = PNW + 1;
    localparam int PCW = 23;                // piece of |n|
    localparam int PPW = PCW + KW;

    logic [7:1] v_reg;

    // C1
    logic signed [PDW-1:0] jh_reg [AXES], jl_reg [AXES];
    logic signed [PNW-1:0] eh_reg [2][AXES], el_reg [2][AXES];
    // C2
    logic signed [SDW-1:0] dh_reg, dl_reg;
    logic signed [SNW-1:0] nh_reg [AXES], nl_reg [AXES];
    // C3
    logic signed [DW-1:0]  det_reg;
    logic signed [NW-1:0]  n_reg [AXES];
    // C4
    logic [DW-1:0]         dmag4_reg;
    logic                  dneg4_reg, sing4_reg;
    logic [NW-1:0]         nmag_reg [AXES];
    logic [AXES-1:0]       nneg4_reg;
    // C5
    logic [PPW-1:0]        pp_reg [AXES][3];
    logic [DW-1:0]         dmag5_reg;
    logic                  dneg5_reg, sing5_reg;
    logic [AXES-1:0]       nneg5_reg;
    // C6
    logic [PW-1:0]         p_reg [AXES];
    logic [DW-1:0]         dmag6_reg;
    logic                  sing6_reg;
    logic [AXES-1:0]       dir6_reg;
    // C7
    dv_t                   dv_reg, dv_next;

    logic [KW-1:0]         k;
    logic [PCW*3-1:0]      nwide [AXES];
    logic [PW-1:0]         dsh8;

    assign k = {gain, 4'b0000};

    always_comb begin
        dsh8 = PW'(dmag6_reg) << 8;
        dv_next.sing = sing6_reg;
        for (int i = 0; i < AXES; i++) begin
            dv_next.ax[i].num  = p_reg[i];
            dv_next.ax[i].den7 = PW'(dmag6_reg) << 7;
            dv_next.ax[i].q    = '0;
            dv_next.ax[i].sat  = (p_reg[i] >= dsh8);
            dv_next.ax[i].kill = sing6_reg || (p_reg[i] == '0);
            dv_next.ax[i].dir  = dir6_reg[i];
        end
        for (int i = 0; i < AXES; i++) begin
            nwide[i] = (PCW*3)'(nmag_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:1], vin};
        end
        if (en) begin
            // C1: split each cofactor into a signed high and unsigned low part
            for (int c = 0; c < AXES; c++) begin
                jh_reg[c] <= $signed(cof.j0[c]) * $signed(cof.cf[0][c][CW-1:CLW]);
                jl_reg[c] <= $signed(cof.j0[c]) * $signed({1'b0, cof.cf[0][c][CLW-1:0]});
                eh_reg[0][c] <= $signed(cof.cf[1][c][CW-1:CLW]) * cof.e1;
                el_reg[0][c] <= $signed({1'b0, cof.cf[1][c][CLW-1:0]}) * cof.e1;
                eh_reg[1][c] <= $signed(cof.cf[2][c][CW-1:CLW]) * cof.e2;
                el_reg[1][c] <= $signed({1'b0, cof.cf[2][c][CLW-1:0]}) * cof.e2;
            end
            // C2
            dh_reg <= SDW'(jh_reg[0]) + SDW'(jh_reg[1]) + SDW'(jh_reg[2]);
            dl_reg <= SDW'(jl_reg[0]) + SDW'(jl_reg[1]) + SDW'(jl_reg[2]);
            for (int c = 0; c < AXES; c++) begin
                nh_reg[c] <= SNW'(eh_reg[0][c]) + SNW'(eh_reg[1][c]);
                nl_reg[c] <= SNW'(el_reg[0][c]) + SNW'(el_reg[1][c]);
            end
            // C3
            det_reg <= (DW'(dh_reg) <<< CLW) + DW'(dl_reg);
            for (int c = 0; c < AXES; c++) begin
                n_reg[c] <= (NW'(nh_reg[c]) <<< CLW) + NW'(nl_reg[c]);
            end
            // C4
            dneg4_reg <= det_reg[DW-1];
            sing4_reg <= (det_reg == '0);
            dmag4_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            for (int c = 0; c < AXES; c++) begin
                nneg4_reg[c] <= n_reg[c][NW-1];
                nmag_reg[c]  <= n_reg[c][NW-1] ? NW'(-n_reg[c]) : NW'(n_reg[c]);
            end
            // C5
            dmag5_reg <= dmag4_reg;
            dneg5_reg <= dneg4_reg;
            sing5_reg <= sing4_reg;
            nneg5_reg <= nneg4_reg;
            for (int c = 0; c < AXES; c++) begin
                for (int s = 0; s < 3; s++) begin
                    pp_reg[c][s] <= nwide[c][s*PCW +: PCW] * k;
                end
            end
            // C6
            dmag6_reg <= dmag5_reg;
            sing6_reg <= sing5_reg;
            for (int c = 0; c < AXES; c++) begin
                dir6_reg[c] <= ~(nneg5_reg[c] ^ dneg5_reg);
                p_reg[c] <= PW'(pp_reg[c][0]) + (PW'(pp_reg[c][1]) << PCW)
                          + (PW'(pp_reg[c][2]) << (2*PCW));
            end
            // C7
            dv_reg <= dv_next;
        end
    end

    assign vout = v_reg[7];
    assign dv   = dv_reg;
endmodule
`default_nettype wire

@@ src/jivl_div_step.sv @@
// One restoring-division stage: one quotient bit per axis.
// Depends on jivl_pkg.
`default_nettype none
module jivl_div_step import jivl_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   en,
    input  wire logic   vin,
    input  wire dv_t    din,
    output logic        vout,
    output dv_t         dout
);
    logic v_reg;
    dv_t  d_reg, d_next;

    // numerator is shifted left each step against a fixed den << 7
    always_comb begin
        d_next = din;
        for (int i = 0; i < AXES; i++) begin
            if (din.ax[i].num >= din.ax[i].den7) begin
                d_next.ax[i].num = (din.ax[i].num - din.ax[i].den7) << 1;
                d_next.ax[i].q   = {din.ax[i].q[SPW-2:0], 1'b1};
            end else begin
                d_next.ax[i].num = din.ax[i].num << 1;
                d_next.ax[i].q   = {din.ax[i].q[SPW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= vin;
        end
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;
endmodule
`default_nettype wire

@@ src/jivl_checker.sv @@
// Port-level checks for the velocity law pipeline, bound to the top level.
// Depends on jivl_pkg.
`default_nettype none
module jivl_checker import jivl_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [OUT_W-1:0]   m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // singular: every direction 1, every speed 0
    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> m_tdata[26:0] == 27'h0040201)
        else $error("singular result carries speed or direction");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready disagrees with output stall");
endmodule

bind jacobian_inverse_velocity_law jivl_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

@@ test/tb_jacobian_inverse_velocity_law.sv @@
// Testbench for jacobian_inverse_velocity_law: directed table, then random phases.
// Depends on jivl_pkg and the block; self-checking against an in-bench predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_jacobian_inverse_velocity_law;
    import jivl_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [IN_W-1:0]  data;
        bit               typed;
        logic [OUT_W-1:0] result;
    } pose_row_t;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 30;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 255;
    localparam int PRESSURE_AT = 300;
    localparam int PRESSURE_HOLD = 400;
    localparam logic [OUT_W-1:0] SPEEDS_IDLE = 32'h0004_0201; // dirs 1, speeds 0
    localparam logic [OUT_W-1:0] SPEEDS_SING = 32'h0804_0201;
    localparam logic [23:0] ONE_Q16 = 24'h01_0000;
    localparam logic [23:0] JMAX = 24'h7F_FFFF;
    localparam logic [23:0] JMIN = 24'h80_0000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [PW16-1:0] cfg_wdata = '0;

    logic signed [15:0] goal_x_m = 0, goal_y_m = 0;
    logic [15:0] gain_m = 0;

    logic [OUT_W-1:0] expected_speeds[$];
    bit   row_typed[$];
    logic [OUT_W-1:0] row_result[$];
    pose_row_t table_rows[$];
    int errors = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int stall_max = 0;

    always #2 aclk = ~aclk;

    jacobian_inverse_velocity_law dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    function automatic wide_t jac_at(logic [IN_W-1:0] d, int k);
        logic signed [23:0] v;
        v = d[32 + 24*k +: 24];
        return wide_t'(v);
    endfunction

    // v = -gain*16*adj(J)*e/det, axes rotated to A=v2, B=v0, C=v1
    function automatic logic [OUT_W-1:0] predict_speeds(logic [IN_W-1:0] d);
        wide_t j[9];
        wide_t e1, e2, det, dmag, n, p, q, k;
        wide_t c1[3], c2[3];
        logic signed [15:0] mx, my;
        logic [OUT_W-1:0] r;
        int src;
        bit dneg;
        for (int i = 0; i < 9; i++) j[i] = jac_at(d, i);
        mx = d[15:0];
        my = d[31:16];
        e1 = wide_t'(mx) - wide_t'(goal_x_m);
        e2 = wide_t'(my) - wide_t'(goal_y_m);
        k = wide_t'({1'b0, gain_m}) * 16;
        det = j[0] * (j[4]*j[8] - j[5]*j[7]) - j[1] * (j[3]*j[8] - j[5]*j[6])
            + j[2] * (j[3]*j[7] - j[4]*j[6]);
        c1[0] = -(j[1]*j[8] - j[2]*j[7]);
        c1[1] = j[0]*j[8] - j[2]*j[6];
        c1[2] = -(j[0]*j[7] - j[1]*j[6]);
        c2[0] = j[1]*j[5] - j[2]*j[4];
        c2[1] = -(j[0]*j[5] - j[2]*j[3]);
        c2[2] = j[0]*j[4] - j[1]*j[3];
        dneg = det < 0;
        dmag = dneg ? -det : det;
        r = '0;
        r[27] = (det == 0);
        for (int a = 0; a < 3; a++) begin
            src = (a == 0) ? 2 : a - 1;
            r[9*a] = 1'b1;
            if (det != 0) begin
                n = c1[src]*e1 + c2[src]*e2;
                p = (n < 0 ? -n : n) * k;
                if (p != 0) begin
                    r[9*a] = ((n < 0) != dneg) ? 1'b0 : 1'b1;
                    q = p / dmag;
                    r[9*a+1 +: 8] = (q > 255) ? 8'd255 : q[7:0];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_pose(logic [15:0] mx, logic [15:0] my,
                                                  logic [23:0] j [9]);
        logic [IN_W-1:0] d;
        d = IN_W'({my, mx});
        for (int i = 0; i < 9; i++) d[32 + 24*i +: 24] = j[i];
        return d;
    endfunction

    function automatic logic [23:0] rand_sym(int sh);
        int v;
        v = int'($urandom_range(0, (1 << (sh + 1)) - 1)) - (1 << sh);
        return v[23:0];
    endfunction

    function automatic logic [IN_W-1:0] random_pose();
        logic [23:0] j[9];
        logic [15:0] mx, my;
        int mode, sh, r0, r1;
        bit dup;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) j[i] = 24'($urandom());
        mx = 16'($urandom());
        my = 16'($urandom());
        if (mode == 2) begin
            // rank-deficient: duplicate a row, or zero a column
            r0 = $urandom_range(0, 2);
            r1 = (r0 + $urandom_range(1, 2)) % 3;
            dup = 1'($urandom_range(0, 1));
            for (int c = 0; c < 3; c++) begin
                if (dup) j[3*r1 + c] = j[3*r0 + c];
                else j[3*c + r0] = '0;
            end
        end else if (mode >= 3) begin
            sh = $urandom_range(4, 22);
            for (int i = 0; i < 9; i++) j[i] = rand_sym(sh - 3);
            for (int i = 0; i < 3; i++) j[4*i] = rand_sym(sh);
            sh = $urandom_range(0, 12);
            mx = goal_x_m + 16'(rand_sym(sh));
            my = goal_y_m + 16'(rand_sym(sh));
        end
        return pack_pose(mx, my, j);
    endfunction

    function automatic logic [IN_W-1:0] diag_pose(logic [15:0] mx, logic [15:0] my,
                                                  logic [23:0] a, logic [23:0] b,
                                                  logic [23:0] c, logic [23:0] off);
        logic [23:0] j[9];
        for (int i = 0; i < 9; i++) j[i] = off;
        j[0] = a;
        j[4] = b;
        j[8] = c;
        return pack_pose(mx, my, j);
    endfunction

    task automatic add_row(logic [IN_W-1:0] d, bit typed, logic [OUT_W-1:0] res);
        table_rows.insert(table_rows.size(), '{d, typed, res});
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        unique case (idx)
            REG_GOAL_X: goal_x_m = val;
            REG_GOAL_Y: goal_y_m = val;
            REG_GAIN:   gain_m = val;
            default: ;
        endcase
    endtask

    task automatic set_servo(logic [15:0] gx, logic [15:0] gy, logic [15:0] g);
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_GAIN, g);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pose(logic [IN_W-1:0] d, int gap_max);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        // let the monitor queue the last transfer first
        @(posedge aclk);
        while (expected_speeds.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // input monitor: the predictor runs on the configuration in force
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (row_typed.size() != 0 && row_typed[0])
                expected_speeds.insert(expected_speeds.size(), row_result[0]);
            else
                expected_speeds.insert(expected_speeds.size(), predict_speeds(s_tdata));
            if (row_typed.size() != 0) begin
                void'(row_typed.pop_front());
                void'(row_result.pop_front());
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        string names[3];
        names = '{"a", "b", "c"};
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_speeds.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = expected_speeds.pop_front();
                for (int a = 0; a < 3; a++) begin
                    if (m_tdata[9*a] !== want[9*a])
                        report_mismatch({"dir_", names[a]}, m_tdata[9*a], want[9*a]);
                    if (m_tdata[9*a+1 +: 8] !== want[9*a+1 +: 8])
                        report_mismatch({"speed_", names[a]}, m_tdata[9*a+1 +: 8],
                                        want[9*a+1 +: 8]);
                end
                if (m_tdata[27] !== want[27])
                    report_mismatch("singular", m_tdata[27], want[27]);
                if (m_tdata[31:28] !== 4'd0)
                    report_mismatch("pad", m_tdata[31:28], 0);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back the pipeline up
    initial begin
        int w;
        bit held;
        held = 0;
        @(posedge aresetn);
        forever begin
            w = $urandom_range(0, stall_max);
            if (!held && results_seen >= PRESSURE_AT) begin
                held = 1;
                w = PRESSURE_HOLD;
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL jacobian_inverse_velocity_law");
            $finish;
        end
    end

    initial begin
        int gmax;
        logic [15:0] gx, gy, g;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset gain is zero: every actuator idle
        add_row(diag_pose(16'h7FFF, 16'h8000, ONE_Q16, ONE_Q16, ONE_Q16, 24'd0),
                1'b1, SPEEDS_IDLE);
        foreach (table_rows[i]) begin
            row_typed.insert(row_typed.size(), table_rows[i].typed);
            row_result.insert(row_result.size(), table_rows[i].result);
            send_pose(table_rows[i].data, 0);
        end
        drain();
        table_rows.delete();

        set_servo(16'd0, 16'd0, 16'h0100);
        // zero error on an identity Jacobian
        add_row(diag_pose(16'd0, 16'd0, ONE_Q16, ONE_Q16, ONE_Q16, 24'd0),
                1'b1, SPEEDS_IDLE);
        // singular: all-zero, all-min and all-max Jacobians
        add_row(diag_pose(16'd16, 16'd16, 24'd0, 24'd0, 24'd0, 24'd0),
                1'b1, SPEEDS_SING);
        add_row(diag_pose(16'h1234, 16'd5, JMIN, JMIN, JMIN, JMIN),
                1'b1, SPEEDS_SING);
        add_row(diag_pose(16'h8000, 16'h7FFF, JMAX, JMAX, JMAX, JMAX),
                1'b1, SPEEDS_SING);
        // identity, small error both signs
        add_row(diag_pose(16'd16, 16'hFFF0, ONE_Q16, ONE_Q16, ONE_Q16, 24'd0),
                1'b0, '0);
        // tiny Jacobian, extreme error: saturates
        add_row(diag_pose(16'h8000, 16'h7FFF, 24'd1, 24'd1, 24'd1, 24'd0),
                1'b0, '0);
        add_row(diag_pose(16'h7FFF, 16'h8000, ONE_Q16, ONE_Q16, ONE_Q16, 24'd0),
                1'b0, '0);
        // huge Jacobian: tiny positive velocity, direction 0 with speed 0
        add_row(diag_pose(16'hFFFF, 16'hFFFF, JMAX, JMAX, JMAX, 24'd0),
                1'b0, '0);
        add_row(diag_pose(16'd1, 16'd1, JMAX, JMAX, JMAX, 24'd0),
                1'b0, '0);
        // negative determinant, extreme then moderate entries; the last matrix is singular
        add_row(diag_pose(16'd400, 16'hFE00, JMIN, JMAX, JMAX, 24'd0),
                1'b0, '0);
        add_row(diag_pose(16'hFF00, 16'd200, JMIN, JMIN, JMIN, 24'd12345),
                1'b0, '0);
        add_row(diag_pose(16'd48, 16'd96, 24'h04_0000, 24'hFE_0000,
                          24'h00_8000, 24'h00_1000), 1'b0, '0);
        add_row(diag_pose(16'd800, 16'hFC00, 24'h10_0000, 24'h10_0000,
                          24'h10_0000, 24'hF8_0000), 1'b0, '0);
        foreach (table_rows[i]) begin
            row_typed.insert(row_typed.size(), table_rows[i].typed);
            row_result.insert(row_result.size(), table_rows[i].result);
            send_pose(table_rows[i].data, i % 2 ? 3 : 0);
        end
        drain();

        // a write to the unused index must change nothing
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_we <= 1'b0;
        send_pose(diag_pose(16'd0, 16'd0, ONE_Q16, ONE_Q16, ONE_Q16, 24'd0), 0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            unique case (ph)
                0: begin gx = 16'h8000; gy = 16'h7FFF; g = 16'hFFFF; end
                1: begin gx = 16'h7FFF; gy = 16'h8000; g = 16'h0001; end
                2: begin gx = 16'($urandom()); gy = 16'($urandom()); g = 16'd0; end
                default: begin
                    gx = 16'($urandom());
                    gy = 16'($urandom());
                    g = $urandom_range(0, 1) ? 16'($urandom())
                                             : 16'($urandom_range(1, 1024));
                end
            endcase
            set_servo(gx, gy, g);
            gmax = (ph % 3 == 2) ? 0 : 19;
            stall_max = gmax;
            for (int i = 0; i < PHASE_ITEMS; i++) send_pose(random_pose(), gmax);
            drain();
        end

        if (errors == 0)
            $display("PASS jacobian_inverse_velocity_law");
        else
            $display("FAIL jacobian_inverse_velocity_law");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
src/jivl_pkg.sv
src/jivl_cofactor.sv
src/jivl_combine.sv
src/jivl_div_step.sv
src/jacobian_inverse_velocity_law.sv
src/jivl_checker.sv
test/tb_jacobian_inverse_velocity_law.sv
